/* hw/rtl/iir4_pkg.sv */
package iir4_pkg;

   localparam int COEF_W    = 32;
   localparam int COEF_FRAC = 28;
   localparam int ACC_W     = 64;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_W-1:0] B0_B1_RESET = 64'h1000_0000_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_B0_B1 = 3'd0,
      CSR_B2_B3 = 3'd1,
      CSR_B4    = 3'd2,
      CSR_A1_A2 = 3'd3,
      CSR_A3_A4 = 3'd4
   } csr_index_type;

   typedef logic signed [COEF_W-1:0] coef_type;

   typedef struct packed {
      coef_type b0;
      coef_type b1;
      coef_type b2;
      coef_type b3;
      coef_type b4;
      coef_type a1;
      coef_type a2;
      coef_type a3;
      coef_type a4;
   } coef_set_type;

endpackage

/* hw/rtl/iir_fourth_order_filter_core.sv */
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_sample_in
// rsp_      out        rsp_valid/rsp_stall  rsp_sample_out, rsp_saturated
// csr_      in         csr_write            csr_index, csr_wdata
//
// One request per cycle while no result is stalled; each result is computed from the
// input register and held in the output register. The rate is set by the combinational
// multiply-accumulate pass that also closes the output-history feedback loop.
// Synchronous reset clears coefficients to pass-through (b0 = 1.0) and both histories.
// A request waits in the input register while a result is stalled; req_stall rises only
// when both registers are full.
module iir_fourth_order_filter_core
   import iir4_pkg::*;
#(
   parameter int SAMPLE_WIDTH      = 16,
   parameter int HISTORY_FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_saturated,
   input  logic                           csr_write,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_W-1:0]               csr_wdata
);

   localparam int HIST_W = SAMPLE_WIDTH + HISTORY_FRAC_BITS;

   logic [CSR_W-1:0]               b0_b1_ff;
   logic [CSR_W-1:0]               b2_b3_ff;
   logic [COEF_W-1:0]              b4_ff;
   logic [CSR_W-1:0]               a1_a2_ff;
   logic [CSR_W-1:0]               a3_a4_ff;
   coef_set_type                   coefs;

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_out_ff;
   logic                           saturated_ff;

   logic signed [SAMPLE_WIDTH-1:0] x_hist_ff [4];
   logic signed [HIST_W-1:0]       y_hist_ff [4];

   logic signed [HIST_W-1:0]       y_hist_next;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           saturated;
   logic                           req_take;
   logic                           advance;

   assign coefs = '{
      b0: b0_b1_ff[CSR_W-1:COEF_W], b1: b0_b1_ff[COEF_W-1:0],
      b2: b2_b3_ff[CSR_W-1:COEF_W], b3: b2_b3_ff[COEF_W-1:0],
      b4: b4_ff,
      a1: a1_a2_ff[CSR_W-1:COEF_W], a2: a1_a2_ff[COEF_W-1:0],
      a3: a3_a4_ff[CSR_W-1:COEF_W], a4: a3_a4_ff[COEF_W-1:0]
   };

   iir4_dp #(
      .SAMPLE_WIDTH      (SAMPLE_WIDTH),
      .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
   ) u_dp (
      .coefs       (coefs),
      .x_new       (x_ff),
      .x_hist      (x_hist_ff),
      .y_hist      (y_hist_ff),
      .y_hist_next (y_hist_next),
      .sample_out  (sample_out),
      .saturated   (saturated)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         b0_b1_ff     <= B0_B1_RESET;
         b2_b3_ff     <= '0;
         b4_ff        <= '0;
         a1_a2_ff     <= '0;
         a3_a4_ff     <= '0;
         for (int i = 0; i < 4; i++) begin
            x_hist_ff[i] <= '0;
            y_hist_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_B0_B1: b0_b1_ff <= csr_wdata;
               CSR_B2_B3: b2_b3_ff <= csr_wdata;
               CSR_B4:    b4_ff    <= csr_wdata[COEF_W-1:0];
               CSR_A1_A2: a1_a2_ff <= csr_wdata;
               CSR_A3_A4: a3_a4_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (advance) begin
            x_hist_ff[0] <= x_ff;
            y_hist_ff[0] <= y_hist_next;
            for (int i = 1; i < 4; i++) begin
               x_hist_ff[i] <= x_hist_ff[i-1];
               y_hist_ff[i] <= y_hist_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff <= req_sample_in;
      end
      if (advance) begin
         sample_out_ff <= sample_out;
         saturated_ff  <= saturated;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = sample_out_ff;
   assign rsp_saturated  = saturated_ff;

endmodule

/* hw/rtl/iir4_dp.sv */
module iir4_dp
   import iir4_pkg::*;
#(
   parameter int SAMPLE_WIDTH      = 16,
   parameter int HISTORY_FRAC_BITS = 8
) (
   input  coef_set_type                                         coefs,
   input  logic signed [SAMPLE_WIDTH-1:0]                       x_new,
   input  logic signed [SAMPLE_WIDTH-1:0]                       x_hist [4],
   input  logic signed [SAMPLE_WIDTH+HISTORY_FRAC_BITS-1:0]     y_hist [4],
   output logic signed [SAMPLE_WIDTH+HISTORY_FRAC_BITS-1:0]     y_hist_next,
   output logic signed [SAMPLE_WIDTH-1:0]                       sample_out,
   output logic                                                 saturated
);

   localparam int HIST_W = SAMPLE_WIDTH + HISTORY_FRAC_BITS;
   localparam int PX_W   = COEF_W + SAMPLE_WIDTH;
   localparam int PY_W   = COEF_W + HIST_W;
   localparam int SH_H   = COEF_FRAC;
   localparam int SH_Y   = COEF_FRAC + HISTORY_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] HALF_H = ACC_W'(1) << (SH_H - 1);
   localparam logic signed [ACC_W-1:0] HALF_Y = ACC_W'(1) << (SH_Y - 1);
   localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
   localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   coef_type                        b [5];
   coef_type                        a [4];
   logic signed [SAMPLE_WIDTH-1:0]  xs [5];
   logic signed [PX_W-1:0]          pb [5];
   logic signed [PY_W-1:0]          pa [4];
   logic signed [ACC_W-1:0]         ff;
   logic signed [ACC_W-1:0]         fb;
   logic signed [ACC_W-1:0]         acc;
   logic signed [ACC_W-1:0]         hr;
   logic signed [ACC_W-1:0]         yr;
   logic                            clip_h;
   logic                            clip_y;

   always_comb begin
      b[0] = coefs.b0;
      b[1] = coefs.b1;
      b[2] = coefs.b2;
      b[3] = coefs.b3;
      b[4] = coefs.b4;
      a[0] = coefs.a1;
      a[1] = coefs.a2;
      a[2] = coefs.a3;
      a[3] = coefs.a4;
      xs[0] = x_new;
      for (int i = 0; i < 4; i++) begin
         xs[i+1] = x_hist[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         pb[i] = PX_W'(b[i]) * PX_W'(xs[i]);
      end
      for (int i = 0; i < 4; i++) begin
         pa[i] = PY_W'(a[i]) * PY_W'(y_hist[i]);
      end
   end

   always_comb begin
      ff = '0;
      for (int i = 0; i < 5; i++) begin
         ff = ff + ACC_W'(pb[i]);
      end
      fb = '0;
      for (int i = 0; i < 4; i++) begin
         fb = fb + ACC_W'(pa[i]);
      end
      acc = (ff <<< HISTORY_FRAC_BITS) - fb;
      hr  = (acc + HALF_H) >>> SH_H;
      yr  = (acc + HALF_Y) >>> SH_Y;
   end

   assign clip_h = !((&hr[ACC_W-1:HIST_W-1]) || !(|hr[ACC_W-1:HIST_W-1]));
   assign clip_y = !((&yr[ACC_W-1:SAMPLE_WIDTH-1]) || !(|yr[ACC_W-1:SAMPLE_WIDTH-1]));

   assign y_hist_next = clip_h ? (hr[ACC_W-1] ? HIST_MIN : HIST_MAX) : hr[HIST_W-1:0];
   assign sample_out  = clip_y ? (yr[ACC_W-1] ? OUT_MIN : OUT_MAX) : yr[SAMPLE_WIDTH-1:0];
   assign saturated   = clip_y;

endmodule

/* hw/rtl/iir4_chk.sv */
module iir4_chk
   import iir4_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input logic                           rsp_saturated
);

   localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_sample_out == OUT_MAX || rsp_sample_out == OUT_MIN))
      else $error("saturated flag set on a value inside the range");

   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while the result side is free");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("accepted request produced no result within two cycles");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind iir_fourth_order_filter_core iir4_chk #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iir4_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out),
   .rsp_saturated  (rsp_saturated)
);
